### hw/rtl/days_to_next_anniversary_assert.svh
// assertion macros for the date offset block
`ifndef DAYS_TO_NEXT_ANNIVERSARY_ASSERT_SVH
`define DAYS_TO_NEXT_ANNIVERSARY_ASSERT_SVH

`ifndef SYNTHESIS
`define DTNA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtna assertion failed");
`define DTNA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtna assertion failed");
`else
`define DTNA_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTNA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/dtna_pkg.sv
package dtna_pkg;

  // field widths
  localparam int CmdW   = 1;
  localparam int YearW  = 8;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int ResW   = 10;

  // working widths
  localparam int WYearW = 10;  // signed year, covers two before up to three after
  localparam int WMonW  = 5;   // signed month, -1..15
  localparam int DoyW   = 9;   // day of year 0..365
  localparam int SumW   = 11;  // result before saturation

  localparam logic [SumW-1:0] MaxResult = 11'd1023;
  localparam logic [DoyW-1:0] CommonLen = 9'd365;

  typedef logic signed [WYearW-1:0] year_t;
  typedef logic signed [WMonW-1:0]  mon_t;
  typedef logic [DoyW-1:0]          doy_t;

  // gregorian rule over 1898..2158: the only centuries are 1900, 2000, 2100
  function automatic logic is_leap(input year_t y);
    return (y[1:0] == 2'b00) && (y != 10'sd0) && (y != 10'sd200);
  endfunction

  function automatic doy_t year_len(input year_t y);
    return CommonLen + {{(DoyW-1){1'b0}}, is_leap(y)};
  endfunction

  // day of year at which each month starts, common year
  function automatic doy_t month_start(input logic [MonthW-1:0] m);
    doy_t s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/dtna_if.sv
// query channel
interface dtna_in_if import dtna_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [YearW-1:0]  year_since_1900;
  logic [MonthW-1:0] cur_month;
  logic [DayW-1:0]   cur_day;
  logic [MonthW-1:0] target_month;
  logic [DayW-1:0]   target_day;

  modport source (
    output valid, command, year_since_1900, cur_month, cur_day, target_month, target_day,
    input  ready
  );
  modport sink (
    input  valid, command, year_since_1900, cur_month, cur_day, target_month, target_day,
    output ready
  );
endinterface

// result channel
interface dtna_out_if import dtna_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ResW-1:0] days_until;

  modport source (output valid, days_until, input ready);
  modport sink (input valid, days_until, output ready);
endinterface

### hw/rtl/dtna_doy.sv
// day of year of a date, with month and day overflow normalized
module dtna_doy import dtna_pkg::*; (
  input  year_t            year,
  input  mon_t             month,
  input  logic [DayW-1:0]  mday,
  output doy_t             doy
);

  year_t                   norm_year;
  logic [MonthW-1:0]       norm_mon;
  logic signed [SumW-1:0]  off;
  logic signed [SumW-1:0]  len_cur;
  logic signed [SumW-1:0]  len_prev;
  logic signed [SumW-1:0]  wrapped;
  logic                    leap_adj;

  // fold month into 0..11, carrying into the year
  always_comb begin
    if (month < 0) begin
      norm_mon  = 4'd11;
      norm_year = year - 10'sd1;
    end else if (month >= 5'sd12) begin
      norm_mon  = month[MonthW-1:0] - 4'd12;
      norm_year = year + 10'sd1;
    end else begin
      norm_mon  = month[MonthW-1:0];
      norm_year = year;
    end
  end

  // raw offset, may run one before the year or past its end
  always_comb begin
    leap_adj = (norm_mon >= 4'd2) ? is_leap(norm_year) : 1'b0;
    off = $signed({2'b00, month_start(norm_mon)})
        + $signed({{(SumW-1){1'b0}}, leap_adj})
        + $signed({{(SumW-DayW){1'b0}}, mday})
        - 11'sd1;
    len_cur  = $signed({2'b00, year_len(norm_year)});
    len_prev = $signed({2'b00, year_len(norm_year - 10'sd1)});
  end

  // wrap into the neighboring year
  always_comb begin
    if (off < 0) begin
      wrapped = off + len_prev;
    end else if (off >= len_cur) begin
      wrapped = off - len_cur;
    end else begin
      wrapped = off;
    end
  end

  assign doy = wrapped[DoyW-1:0];

endmodule

### hw/rtl/days_to_next_anniversary.sv
// channel  dir  modport  beat
// in_ch    in   sink     command, year, current month/day, target month/day
// out_ch   out  source   days_until
//
// three register stages: query, day-of-year, result; one beat per cycle unless out_ch stalls.
// an accepted query moves through the query, day-of-year and result registers in turn to out_ch.
// rst clears the stage valid bits only; payload registers hold garbage.
// a stall on out_ch holds each full stage and fills empty ones before
// in_ch.ready drops.
module days_to_next_anniversary import dtna_pkg::*; (
  input logic        clk,
  input logic        rst,
  dtna_in_if.sink    in_ch,
  dtna_out_if.source out_ch
);

  typedef struct packed {
    logic cmd;
    doy_t cur;
    doy_t t0;
    doy_t t1;
    doy_t t2;
    doy_t len0;
    doy_t len1;
  } mid_t;

  // stage 1: query register
  logic              s1_valid;
  logic [CmdW-1:0]   s1_cmd;
  logic [YearW-1:0]  s1_year;
  logic [MonthW-1:0] s1_cm;
  logic [DayW-1:0]   s1_cd;
  logic [MonthW-1:0] s1_tm;
  logic [DayW-1:0]   s1_td;

  // stage 2: day-of-year register
  logic s2_valid;
  mid_t s2_mid;
  mid_t s2_mid_next;

  // stage 3: result register
  logic            out_valid;
  logic [ResW-1:0] out_days;
  logic [ResW-1:0] out_days_next;

  logic s1_move;
  logic s2_move;
  logic out_move;

  year_t y0;
  year_t y1;
  year_t y2;
  mon_t  cur_mon;
  mon_t  tgt_mon;
  doy_t  cur_doy;
  doy_t  t0_doy;
  doy_t  t1_doy;
  doy_t  t2_doy;

  logic [SumW-1:0] rest0;
  logic [SumW-1:0] sum;

  // stall chain
  assign out_move    = !out_valid || out_ch.ready;
  assign s2_move     = !s2_valid || out_move;
  assign s1_move     = !s1_valid || s2_move;
  assign in_ch.ready = s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move) s1_valid <= in_ch.valid;
      if (s2_move) s2_valid <= s1_valid;
      if (out_move) out_valid <= s2_valid;
    end
  end

  // query capture
  always_ff @(posedge clk) begin
    if (s1_move && in_ch.valid) begin
      s1_cmd  <= in_ch.command;
      s1_year <= in_ch.year_since_1900;
      s1_cm   <= in_ch.cur_month;
      s1_cd   <= in_ch.cur_day;
      s1_tm   <= in_ch.target_month;
      s1_td   <= in_ch.target_day;
    end
  end

  // years and months in signed working form, target month made 0-based
  assign y0      = $signed({{(WYearW-YearW){1'b0}}, s1_year});
  assign y1      = y0 + 10'sd1;
  assign y2      = y0 + 10'sd2;
  assign cur_mon = $signed({1'b0, s1_cm});
  assign tgt_mon = $signed({1'b0, s1_tm}) - 5'sd1;

  dtna_doy u_cur (.year(y0), .month(cur_mon), .mday(s1_cd), .doy(cur_doy));
  dtna_doy u_t0  (.year(y0), .month(tgt_mon), .mday(s1_td), .doy(t0_doy));
  dtna_doy u_t1  (.year(y1), .month(tgt_mon), .mday(s1_td), .doy(t1_doy));
  dtna_doy u_t2  (.year(y2), .month(tgt_mon), .mday(s1_td), .doy(t2_doy));

  always_comb begin
    s2_mid_next.cmd  = s1_cmd[0];
    s2_mid_next.cur  = cur_doy;
    s2_mid_next.t0   = t0_doy;
    s2_mid_next.t1   = t1_doy;
    s2_mid_next.t2   = t2_doy;
    s2_mid_next.len0 = year_len(y0);
    s2_mid_next.len1 = year_len(y1);
  end

  always_ff @(posedge clk) begin
    if (s2_move && s1_valid) begin
      s2_mid <= s2_mid_next;
    end
  end

  // pick the occurrence and saturate
  always_comb begin
    rest0 = {2'b00, s2_mid.len0} - {2'b00, s2_mid.cur};
    if (s2_mid.t0 >= s2_mid.cur) begin
      if (!s2_mid.cmd) begin
        sum = {2'b00, s2_mid.t0} - {2'b00, s2_mid.cur};
      end else begin
        sum = rest0 + {2'b00, s2_mid.t1};
      end
    end else begin
      if (!s2_mid.cmd) begin
        sum = rest0 + {2'b00, s2_mid.t1};
      end else begin
        sum = rest0 + {2'b00, s2_mid.len1} + {2'b00, s2_mid.t2};
      end
    end
    out_days_next = (sum > MaxResult) ? MaxResult[ResW-1:0] : sum[ResW-1:0];
  end

  always_ff @(posedge clk) begin
    if (out_move && s2_valid) begin
      out_days <= out_days_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.days_until = out_days;

`include "days_to_next_anniversary_assert.svh"

  `DTNA_ASSERT_NXT(a_accept_fills_s1, clk, rst, in_ch.valid && in_ch.ready, s1_valid)
  `DTNA_ASSERT_IMP(a_ready_when_s1_empty, clk, rst, !s1_valid, in_ch.ready)
  `DTNA_ASSERT_NXT(a_s2_held_on_stall, clk, rst, s2_valid && !out_move, s2_valid && $stable(s2_mid))

endmodule

### dv/days_to_next_anniversary_checker.sv
// watches both channels, predicts days_until for each accepted query beat
// and compares it with the result beats in order
module days_to_next_anniversary_checker import dtna_pkg::*; (
  input  logic clk,
  input  logic rst,
  dtna_in_if   in_ch,
  dtna_out_if  out_ch,
  output int   mismatches,
  output int   pending,
  output int   checked
);

  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int ResultCap = (1 << ResW) - 1;

  // one outstanding query with the answer it should produce
  typedef struct {
    logic [CmdW-1:0]   command;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] cur_month;
    logic [DayW-1:0]   cur_day;
    logic [MonthW-1:0] target_month;
    logic [DayW-1:0]   target_day;
    logic [ResW-1:0]   days;
  } due_t;

  due_t due_q[$];
  due_t head;
  due_t fresh;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  // gregorian rule on the full year
  function automatic int leap_year_at(input int y);
    int full;
    full = y + 1900;
    return (((full % 4) == 0 && (full % 100) != 0) || (full % 400) == 0) ? 1 : 0;
  endfunction

  function automatic int year_days(input int y);
    return 365 + leap_year_at(y);
  endfunction

  // zero-based day of year after month carry and day roll-over
  function automatic int day_of_year(input int y, input int mon, input int mday);
    int yy;
    int mm;
    int off;
    int i;
    yy = y;
    mm = mon;
    if (mm < 0) begin
      mm += 12;
      yy -= 1;
    end
    while (mm >= 12) begin
      mm -= 12;
      yy += 1;
    end
    off = mday - 1;
    for (i = 0; i < mm; i++) off += MonthDays[i];
    if (mm >= 2) off += leap_year_at(yy);
    if (off < 0) begin
      off += year_days(yy - 1);
    end else if (off >= year_days(yy)) begin
      off -= year_days(yy);
    end
    return off;
  endfunction

  // days until the next (command 0) or the following (command 1) occurrence
  function automatic logic [ResW-1:0] days_to_target(
    input logic [CmdW-1:0]   cmd,
    input logic [YearW-1:0]  year,
    input logic [MonthW-1:0] cm,
    input logic [DayW-1:0]   cd,
    input logic [MonthW-1:0] tm,
    input logic [DayW-1:0]   td
  );
    int y;
    int now;
    int left_in_year;
    int t_this;
    int t_next;
    int t_after;
    int span;
    y            = int'(year);
    now          = day_of_year(y, int'(cm), int'(cd));
    left_in_year = day_of_year(y, 11, 31) - now;
    t_this       = day_of_year(y, int'(tm) - 1, int'(td));
    t_next       = day_of_year(y + 1, int'(tm) - 1, int'(td));
    if (cmd == 1'b0) begin
      span = (t_this >= now) ? (t_this - now) : (left_in_year + t_next + 1);
    end else if (t_this >= now) begin
      span = left_in_year + t_next + 1;
    end else begin
      t_after = day_of_year(y + 2, int'(tm) - 1, int'(td));
      span = left_in_year + day_of_year(y + 1, 11, 31) + 1 + t_after + 1;
    end
    if (span < 0) span = 0;
    if (span > ResultCap) span = ResultCap;
    return span[ResW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // query beats push a prediction, result beats pop and compare
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        fresh.command      = in_ch.command;
        fresh.year         = in_ch.year_since_1900;
        fresh.cur_month    = in_ch.cur_month;
        fresh.cur_day      = in_ch.cur_day;
        fresh.target_month = in_ch.target_month;
        fresh.target_day   = in_ch.target_day;
        fresh.days = days_to_target(in_ch.command, in_ch.year_since_1900, in_ch.cur_month,
                                    in_ch.cur_day, in_ch.target_month, in_ch.target_day);
        due_q.push_back(fresh);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no query waiting", out_ch.days_until));
        end else begin
          head = due_q.pop_front();
          checked++;
          if (out_ch.days_until !== head.days) begin
            report_mismatch($sformatf(
              "days_until %0d, want %0d (cmd %0d year %0d cur %0d/%0d target %0d/%0d)",
              out_ch.days_until, head.days, head.command, head.year, head.cur_month,
              head.cur_day, head.target_month, head.target_day));
          end
        end
      end
    end
    pending = due_q.size();
  end

endmodule

### dv/days_to_next_anniversary_tb.sv
// stimulus and verdict for the anniversary day-count block
module days_to_next_anniversary_tb import dtna_pkg::*; ();

  localparam int LastCycle   = 200000;
  localparam int DrainCycles = 10;
  localparam int RandomItems = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtna_in_if  in_ch ();
  dtna_out_if out_ch ();

  int  mismatches;
  int  pending;
  int  checked;
  int  cycles = 0;
  int  sent = 0;
  int  directed = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  days_to_next_anniversary dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  days_to_next_anniversary_checker days_check (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LastCycle) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  // present one query beat, hold it until taken, then maybe idle
  task automatic send_query(
    input logic [CmdW-1:0]   cmd,
    input logic [YearW-1:0]  year,
    input logic [MonthW-1:0] cm,
    input logic [DayW-1:0]   cd,
    input logic [MonthW-1:0] tm,
    input logic [DayW-1:0]   td
  );
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd;
    in_ch.year_since_1900 <= year;
    in_ch.cur_month       <= cm;
    in_ch.cur_day         <= cd;
    in_ch.target_month    <= tm;
    in_ch.target_day      <= td;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    sent++;
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
  endtask

  // mostly calendar-valid dates, some fields pushed to their full width
  task automatic random_query();
    logic [MonthW-1:0] cm;
    logic [DayW-1:0]   cd;
    logic [MonthW-1:0] tm;
    logic [DayW-1:0]   td;
    cm = ($urandom_range(0, 9) == 0) ? MonthW'($urandom_range(0, 15))
                                     : MonthW'($urandom_range(0, 11));
    cd = ($urandom_range(0, 9) == 0) ? DayW'($urandom_range(0, 31))
                                     : DayW'($urandom_range(1, 31));
    tm = ($urandom_range(0, 9) == 0) ? MonthW'($urandom_range(0, 15))
                                     : MonthW'($urandom_range(1, 12));
    td = ($urandom_range(0, 9) == 0) ? DayW'($urandom_range(0, 31))
                                     : DayW'($urandom_range(1, 31));
    send_query(CmdW'($urandom_range(0, 1)), YearW'($urandom_range(0, 255)), cm, cd, tm, td);
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.command         = '0;
    in_ch.year_since_1900 = '0;
    in_ch.cur_month       = '0;
    in_ch.cur_day         = '0;
    in_ch.target_month    = '0;
    in_ch.target_day      = '0;
    out_ch.ready          = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: year extremes, leap centuries, both commands
    send_query(1'b0, 8'd0,   4'd0,  5'd1,  4'd1,  5'd1);
    send_query(1'b1, 8'd0,   4'd0,  5'd1,  4'd1,  5'd1);
    send_query(1'b0, 8'd255, 4'd11, 5'd31, 4'd12, 5'd31);
    send_query(1'b1, 8'd255, 4'd11, 5'd31, 4'd1,  5'd1);
    send_query(1'b0, 8'd100, 4'd1,  5'd29, 4'd3,  5'd1);
    send_query(1'b1, 8'd200, 4'd1,  5'd28, 4'd2,  5'd29);
    send_query(1'b0, 8'd96,  4'd2,  5'd1,  4'd2,  5'd30);
    send_query(1'b1, 8'd99,  4'd11, 5'd31, 4'd2,  5'd29);
    send_query(1'b0, 8'd104, 4'd11, 5'd31, 4'd1,  5'd1);
    send_query(1'b0, 8'd123, 4'd6,  5'd15, 4'd7,  5'd31);
    send_query(1'b1, 8'd123, 4'd6,  5'd15, 4'd7,  5'd14);
    send_query(1'b1, 8'd0,   4'd0,  5'd1,  4'd12, 5'd31);
    // month carry into the next year and target month zero
    send_query(1'b0, 8'd50,  4'd12, 5'd1,  4'd1,  5'd1);
    send_query(1'b1, 8'd50,  4'd15, 5'd31, 4'd15, 5'd31);
    send_query(1'b0, 8'd50,  4'd5,  5'd10, 4'd0,  5'd15);
    send_query(1'b0, 8'd0,   4'd15, 5'd31, 4'd13, 5'd31);
    send_query(1'b0, 8'd255, 4'd0,  5'd31, 4'd14, 5'd31);
    // day zero, including january of 1900
    send_query(1'b1, 8'd101, 4'd0,  5'd0,  4'd13, 5'd0);
    send_query(1'b0, 8'd0,   4'd0,  5'd0,  4'd1,  5'd0);
    send_query(1'b1, 8'd255, 4'd15, 5'd0,  4'd0,  5'd0);
    directed = sent;

    // random queries in phases, some with no idling at all
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      random_query();
    end
    in_ch.valid <= 1'b0;

    // drain
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("tb: %0d queries sent (%0d directed), %0d results compared in %0d cycles",
             sent, directed, checked, cycles);
    $display("tb: covered both commands, years 1900-2155, month carry, day zero, leap days");
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
